// File: rtl/sdc_pkg.sv
`timescale 1ns / 1ps

package sdc_pkg;

    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_OPEN     = 3'd1,
        OP_CLOSE    = 3'd2,
        OP_STOP     = 3'd3,
        OP_SET_TIME = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_UNKNOWN = 3'd0,
        MODE_OPEN    = 3'd1,
        MODE_CLOSED  = 3'd2,
        MODE_OPENING = 3'd3,
        MODE_CLOSING = 3'd4,
        MODE_BLOCKED = 3'd5
    } t_door_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCHEDULE_ENABLE = 3'd0,
        REG_OPEN_HOUR       = 3'd1,
        REG_OPEN_MINUTE     = 3'd2,
        REG_CLOSE_HOUR      = 3'd3,
        REG_CLOSE_MINUTE    = 3'd4,
        REG_STEP_INTERVAL   = 3'd5,
        REG_MOVE_TIMEOUT    = 3'd6
    } t_cfg_reg;

    localparam logic [4:0]  OPEN_HOUR_RST     = 5'd7;
    localparam logic [5:0]  OPEN_MINUTE_RST   = 6'd0;
    localparam logic [4:0]  CLOSE_HOUR_RST    = 5'd18;
    localparam logic [5:0]  CLOSE_MINUTE_RST  = 6'd0;
    localparam logic [7:0]  STEP_INTERVAL_RST = 8'd5;
    localparam logic [15:0] MOVE_TIMEOUT_RST  = 16'd25000;
    localparam logic [6:0]  FIRE_NONE         = 7'd127;

    // half-step coil patterns, bit0 is the first coil
    localparam logic [3:0] COIL_TABLE [PHASE_COUNT] = '{
        4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
    };

    typedef struct packed {
        t_door_mode  mode;
        logic [15:0] move_el;
        logic [7:0]  step_el;
    } t_motion;

endpackage

// File: rtl/sdc_in_if.sv
`timescale 1ns / 1ps

interface sdc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic       open_switch_hit;
    logic       closed_switch_hit;
    logic [4:0] time_hour;
    logic [5:0] time_minute;

    modport source (
        output valid, opcode, open_switch_hit, closed_switch_hit, time_hour, time_minute,
        input  ready
    );
    modport sink (
        input  valid, opcode, open_switch_hit, closed_switch_hit, time_hour, time_minute,
        output ready
    );
endinterface

// File: rtl/sdc_out_if.sv
`timescale 1ns / 1ps

interface sdc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_drive;
    logic [2:0] door_status;
    logic       step_taken;

    modport source (
        output valid, coil_drive, door_status, step_taken,
        input  ready
    );
    modport sink (
        input  valid, coil_drive, door_status, step_taken,
        output ready
    );
endinterface

// File: rtl/stepper_door_controller_core.sv
`timescale 1ns / 1ps

// Half-step stepper door controller. Each request (1 ms tick, open, close, stop
// or set time) gives exactly one result: the coil pattern, the door status after
// the request and a flag for a phase advance. One request is taken every clock
// unless the output stalls; a request passes the input register, then the
// result register, and the whole door update (schedule check, move start, limit
// switch stop, timeout, phase step) is one combinational pass between the two.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata
// by the user only while no request is in flight; the block does not enforce it.

module stepper_door_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sdc_in_if.sink                             i_cmd,
    sdc_out_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sdc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // configuration
    logic        r_sched_en;
    logic [4:0]  r_open_hour;
    logic [5:0]  r_open_minute;
    logic [4:0]  r_close_hour;
    logic [5:0]  r_close_minute;
    logic [7:0]  r_interval;
    logic [15:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_op;
    logic        r_sw_open;
    logic        r_sw_closed;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;

    // door state
    sdc_pkg::t_door_mode         r_mode;
    logic [sdc_pkg::PHASE_W-1:0] r_phase;
    logic [3:0]                  r_coil;
    logic [15:0]                 r_move_el;
    logic [7:0]                  r_step_el;
    logic                        r_clock_valid;
    logic [4:0]                  r_clock_hour;
    logic [5:0]                  r_clock_minute;
    logic [6:0]                  r_last_open;
    logic [6:0]                  r_last_close;

    // result register
    logic                r_out_valid;
    logic [3:0]          r_out_coil;
    sdc_pkg::t_door_mode r_out_status;
    logic                r_out_step;

    sdc_pkg::t_motion            n_motion;
    logic [sdc_pkg::PHASE_W-1:0] n_phase;
    logic [3:0]                  n_coil;
    logic                        n_clock_valid;
    logic [4:0]                  n_clock_hour;
    logic [5:0]                  n_clock_minute;
    logic [6:0]                  n_last_open;
    logic [6:0]                  n_last_close;
    logic                        n_step;

    logic advance;
    logic in_fire;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.coil_drive  = r_out_coil;
    assign o_res.door_status = r_out_status;
    assign o_res.step_taken  = r_out_step;

    function automatic sdc_pkg::t_motion f_start_move(
        input sdc_pkg::t_motion s,
        input logic             want_open,
        input logic             sw_open,
        input logic             sw_closed
    );
        sdc_pkg::t_motion r;
        r = s;
        if (want_open && (sw_open || s.mode == sdc_pkg::MODE_OPEN)) begin
            r.mode = sdc_pkg::MODE_OPEN;
        end else if (!want_open && (sw_closed || s.mode == sdc_pkg::MODE_CLOSED)) begin
            r.mode = sdc_pkg::MODE_CLOSED;
        end else if ((want_open && s.mode == sdc_pkg::MODE_OPENING) ||
                     (!want_open && s.mode == sdc_pkg::MODE_CLOSING)) begin
            r = s;
        end else begin
            r.mode    = want_open ? sdc_pkg::MODE_OPENING : sdc_pkg::MODE_CLOSING;
            r.move_el = '0;
            // first tick of a move steps at once
            r.step_el = '1;
        end
        return r;
    endfunction

    always_comb begin
        n_motion       = '{mode: r_mode, move_el: r_move_el, step_el: r_step_el};
        n_phase        = r_phase;
        n_coil         = r_coil;
        n_clock_valid  = r_clock_valid;
        n_clock_hour   = r_clock_hour;
        n_clock_minute = r_clock_minute;
        n_last_open    = r_last_open;
        n_last_close   = r_last_close;
        n_step         = 1'b0;
        unique case (r_op)
            sdc_pkg::OP_TICK: begin
                if (r_sched_en && r_clock_valid) begin
                    if (r_clock_hour == r_open_hour && r_clock_minute == r_open_minute) begin
                        if (r_last_open != {1'b0, r_clock_minute}) begin
                            n_last_open = {1'b0, r_clock_minute};
                            if (n_motion.mode != sdc_pkg::MODE_OPEN &&
                                n_motion.mode != sdc_pkg::MODE_OPENING) begin
                                n_motion = f_start_move(n_motion, 1'b1, r_sw_open, r_sw_closed);
                            end
                        end
                    end else begin
                        n_last_open = sdc_pkg::FIRE_NONE;
                    end
                    if (r_clock_hour == r_close_hour && r_clock_minute == r_close_minute) begin
                        if (r_last_close != {1'b0, r_clock_minute}) begin
                            n_last_close = {1'b0, r_clock_minute};
                            if (n_motion.mode != sdc_pkg::MODE_CLOSED &&
                                n_motion.mode != sdc_pkg::MODE_CLOSING) begin
                                n_motion = f_start_move(n_motion, 1'b0, r_sw_open, r_sw_closed);
                            end
                        end
                    end else begin
                        n_last_close = sdc_pkg::FIRE_NONE;
                    end
                end
                if (n_motion.mode == sdc_pkg::MODE_OPENING ||
                    n_motion.mode == sdc_pkg::MODE_CLOSING) begin
                    if (n_motion.move_el != '1) begin
                        n_motion.move_el = n_motion.move_el + 16'd1;
                    end
                    if (n_motion.step_el != '1) begin
                        n_motion.step_el = n_motion.step_el + 8'd1;
                    end
                    if (n_motion.mode == sdc_pkg::MODE_OPENING && r_sw_open) begin
                        n_coil        = '0;
                        n_motion.mode = sdc_pkg::MODE_OPEN;
                    end else if (n_motion.mode == sdc_pkg::MODE_CLOSING && r_sw_closed) begin
                        n_coil        = '0;
                        n_motion.mode = sdc_pkg::MODE_CLOSED;
                    end else if (n_motion.move_el > r_timeout) begin
                        n_coil        = '0;
                        n_motion.mode = sdc_pkg::MODE_BLOCKED;
                    end else if (n_motion.step_el >= r_interval) begin
                        n_motion.step_el = '0;
                        // phase wraps modulo the pattern length
                        if (n_motion.mode == sdc_pkg::MODE_OPENING) begin
                            n_phase = r_phase + sdc_pkg::PHASE_W'(1);
                        end else begin
                            n_phase = r_phase - sdc_pkg::PHASE_W'(1);
                        end
                        n_coil = sdc_pkg::COIL_TABLE[n_phase];
                        n_step = 1'b1;
                    end
                end
            end
            sdc_pkg::OP_OPEN: begin
                n_motion = f_start_move(n_motion, 1'b1, r_sw_open, r_sw_closed);
            end
            sdc_pkg::OP_CLOSE: begin
                n_motion = f_start_move(n_motion, 1'b0, r_sw_open, r_sw_closed);
            end
            sdc_pkg::OP_STOP: begin
                n_coil = '0;
                if (r_sw_open) begin
                    n_motion.mode = sdc_pkg::MODE_OPEN;
                end else if (r_sw_closed) begin
                    n_motion.mode = sdc_pkg::MODE_CLOSED;
                end else begin
                    n_motion.mode = sdc_pkg::MODE_UNKNOWN;
                end
            end
            sdc_pkg::OP_SET_TIME: begin
                n_clock_hour   = r_hour;
                n_clock_minute = r_minute;
                n_clock_valid  = 1'b1;
            end
            default: begin
                n_step = 1'b0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_en     <= 1'b0;
            r_open_hour    <= sdc_pkg::OPEN_HOUR_RST;
            r_open_minute  <= sdc_pkg::OPEN_MINUTE_RST;
            r_close_hour   <= sdc_pkg::CLOSE_HOUR_RST;
            r_close_minute <= sdc_pkg::CLOSE_MINUTE_RST;
            r_interval     <= sdc_pkg::STEP_INTERVAL_RST;
            r_timeout      <= sdc_pkg::MOVE_TIMEOUT_RST;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= sdc_pkg::MODE_UNKNOWN;
            r_phase        <= '0;
            r_coil         <= '0;
            r_move_el      <= '0;
            r_step_el      <= '0;
            r_clock_valid  <= 1'b0;
            r_clock_hour   <= '0;
            r_clock_minute <= '0;
            r_last_open    <= sdc_pkg::FIRE_NONE;
            r_last_close   <= sdc_pkg::FIRE_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdc_pkg::REG_SCHEDULE_ENABLE: r_sched_en     <= i_cfg_wdata[0];
                    sdc_pkg::REG_OPEN_HOUR:       r_open_hour    <= i_cfg_wdata[4:0];
                    sdc_pkg::REG_OPEN_MINUTE:     r_open_minute  <= i_cfg_wdata[5:0];
                    sdc_pkg::REG_CLOSE_HOUR:      r_close_hour   <= i_cfg_wdata[4:0];
                    sdc_pkg::REG_CLOSE_MINUTE:    r_close_minute <= i_cfg_wdata[5:0];
                    sdc_pkg::REG_STEP_INTERVAL:   r_interval     <= i_cfg_wdata[7:0];
                    sdc_pkg::REG_MOVE_TIMEOUT:    r_timeout      <= i_cfg_wdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_mode         <= n_motion.mode;
                r_phase        <= n_phase;
                r_coil         <= n_coil;
                r_move_el      <= n_motion.move_el;
                r_step_el      <= n_motion.step_el;
                r_clock_valid  <= n_clock_valid;
                r_clock_hour   <= n_clock_hour;
                r_clock_minute <= n_clock_minute;
                r_last_open    <= n_last_open;
                r_last_close   <= n_last_close;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op        <= i_cmd.opcode;
            r_sw_open   <= i_cmd.open_switch_hit;
            r_sw_closed <= i_cmd.closed_switch_hit;
            r_hour      <= i_cmd.time_hour;
            r_minute    <= i_cmd.time_minute;
        end
        if (advance) begin
            r_out_coil   <= n_coil;
            r_out_status <= n_motion.mode;
            r_out_step   <= n_step;
        end
    end

    // a phase step only happens while the door is moving
    a_step_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_step) |->
            (r_out_status == sdc_pkg::MODE_OPENING || r_out_status == sdc_pkg::MODE_CLOSING))
        else $error("step reported while door not moving");

    // coils follow the stored phase right after a step
    a_step_coil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_step) |-> (r_coil == sdc_pkg::COIL_TABLE[r_phase]))
        else $error("coil pattern does not match phase after step");

    // a blocked door never has its coils energized
    a_blocked_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sdc_pkg::MODE_BLOCKED) |-> (r_coil == 4'd0))
        else $error("coils driven while blocked");

    // a waiting request in the input register is not lost while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_op)))
        else $error("stalled request dropped from input register");

endmodule
